### rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment display driver package
// Pin maps, digit patterns and the port word builder shared by the driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  localparam int DigitCountDefault = 4;
  localparam int DigitPins         = 4;
  localparam int PosW              = 2;
  localparam int ValueW            = 14;
  localparam int DwellW            = 8;
  localparam int PortW             = 16;
  localparam int QuotW             = 11;

  localparam logic [DwellW-1:0] DwellReset = 8'd5;

  // Reciprocal of ten scaled by 2^16; exact for every 14-bit operand.
  localparam logic [12:0] RecipTen   = 13'd6554;
  localparam int          RecipShift = 16;

  localparam logic [3:0] SegPin [8] = '{4'd14, 4'd1, 4'd3, 4'd2,
                                        4'd13, 4'd0, 4'd15, 4'd11};
  localparam logic [3:0] DigPin [DigitPins] = '{4'd6, 4'd7, 4'd9, 4'd8};

  function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'b0111_0111;
      4'd1:    pat = 8'b0010_0100;
      4'd2:    pat = 8'b0101_1101;
      4'd3:    pat = 8'b0110_1101;
      4'd4:    pat = 8'b0010_1110;
      4'd5:    pat = 8'b0110_1011;
      4'd6:    pat = 8'b0111_1011;
      4'd7:    pat = 8'b0010_0101;
      4'd8:    pat = 8'b0111_1111;
      4'd9:    pat = 8'b0110_1111;
      default: pat = 8'b0000_0000;
    endcase
    return pat;
  endfunction

  function automatic logic [PortW-1:0] port_word(input logic [PosW-1:0] pos,
                                                 input logic [3:0]      digit);
    logic [PortW-1:0] word;
    logic [7:0]       pat;
    word = '1;
    pat  = digit_pattern(digit);
    for (int j = 0; j < DigitPins; j++) begin
      word[DigPin[j]] = 1'b0;
    end
    word[DigPin[pos]] = 1'b1;
    for (int j = 0; j < 8; j++) begin
      if (pat[j]) begin
        word[SegPin[j]] = 1'b0;
      end
    end
    return word;
  endfunction

endpackage

`default_nettype wire

### rtl/core/seven_segment_mux_display_driver.sv
// ----------------------------------------------------------------------------
// Multiplexed seven-segment display driver
// Scans the decimal digits of a latched value, one digit per dwell period.
// ----------------------------------------------------------------------------
// An accepted input beat's result beat is registered and appears in the next cycle.
// Throughput is one beat per cycle while out_ready_i is high, set by the single result register.
// The running decimal quotient is divided by ten with one constant multiply when the scan advances a digit.
// Reset clears the scan position, dwell count and result valid, and sets
// the dwell register to five.
`default_nettype none

module seven_segment_mux_display_driver #(
  parameter int DIGIT_COUNT = ssd_pkg::DigitCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [ssd_pkg::DwellW-1:0]    cfg_dwell_ticks_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [ssd_pkg::ValueW-1:0]    shown_value_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [ssd_pkg::PortW-1:0]     port_pins_o,
  output      logic [ssd_pkg::PosW-1:0]      active_digit_o
);

  localparam int UsedDigits = (DIGIT_COUNT < 1) ? 1 :
                              (DIGIT_COUNT > ssd_pkg::DigitPins) ? ssd_pkg::DigitPins :
                              DIGIT_COUNT;
  localparam logic [ssd_pkg::PosW:0] UsedDigitsW = (ssd_pkg::PosW+1)'(UsedDigits);

  logic [ssd_pkg::DwellW-1:0] dwell_q;
  logic [ssd_pkg::PosW-1:0]   pos_q, pos_d;
  logic [ssd_pkg::DwellW-1:0] count_q, count_d;
  logic [ssd_pkg::ValueW-1:0] quot_q, quot_d;
  logic                       valid_q;
  logic [ssd_pkg::PortW-1:0]  pins_q;
  logic [ssd_pkg::PosW-1:0]   digit_q;

  logic                       accept;
  logic [ssd_pkg::PosW-1:0]   pos_cur;
  logic [ssd_pkg::PosW:0]     pos_inc;
  logic [ssd_pkg::ValueW-1:0] cur;
  logic [26:0]                product;
  logic [ssd_pkg::QuotW-1:0]  tenth;
  logic [ssd_pkg::ValueW-1:0] tenth_x10;
  logic [ssd_pkg::ValueW-1:0] rem_full;
  logic [ssd_pkg::DwellW-1:0] dwell_eff;
  logic [ssd_pkg::DwellW-1:0] count_inc;
  logic                       advance;

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = !valid_q || out_ready_i;
  assign accept         = in_valid_i && in_ready_o;
  assign out_valid_o    = valid_q;
  assign port_pins_o    = pins_q;
  assign active_digit_o = digit_q;

  always_comb begin
    pos_cur   = ({1'b0, pos_q} >= UsedDigitsW) ? '0 : pos_q;
    cur       = (pos_cur == '0 && count_q == '0) ? shown_value_i : quot_q;
    product   = 27'(cur) * 27'(ssd_pkg::RecipTen);
    tenth     = product[ssd_pkg::RecipShift +: ssd_pkg::QuotW];
    tenth_x10 = ssd_pkg::ValueW'({tenth, 3'b000}) + ssd_pkg::ValueW'({tenth, 1'b0});
    rem_full  = cur - tenth_x10;
    dwell_eff = (dwell_q == '0) ? ssd_pkg::DwellW'(1) : dwell_q;
    count_inc = count_q + ssd_pkg::DwellW'(1);
    advance   = (count_inc >= dwell_eff) || (count_inc == '0);
    pos_inc   = {1'b0, pos_cur} + (ssd_pkg::PosW+1)'(1);
    if (advance) begin
      count_d = '0;
      quot_d  = ssd_pkg::ValueW'(tenth);
      pos_d   = (pos_inc >= UsedDigitsW) ? '0 : pos_inc[ssd_pkg::PosW-1:0];
    end else begin
      count_d = count_inc;
      quot_d  = cur;
      pos_d   = pos_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q <= ssd_pkg::DwellReset;
      pos_q   <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        dwell_q <= cfg_dwell_ticks_i;
      end
      if (accept) begin
        pos_q   <= pos_d;
        count_q <= count_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      quot_q  <= quot_d;
      pins_q  <= ssd_pkg::port_word(pos_cur, rem_full[3:0]);
      digit_q <= pos_cur;
    end
  end

  a_result_follows_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o
  ) else $error("accepted beat produced no result");

  a_digit_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, active_digit_o} < UsedDigitsW)
  ) else $error("active digit beyond the used digit count");

  a_one_digit_pin: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({port_pins_o[ssd_pkg::DigPin[0]], port_pins_o[ssd_pkg::DigPin[1]],
                             port_pins_o[ssd_pkg::DigPin[2]], port_pins_o[ssd_pkg::DigPin[3]]})
  ) else $error("digit select pins not one-hot");

  a_pin_matches_digit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> port_pins_o[ssd_pkg::DigPin[active_digit_o]]
  ) else $error("lit digit pin does not match active digit");

endmodule

`default_nettype wire
